FILE: rtl/core/bertlv_pkg.sv
// Shared byte-role and error codes for the BER-TLV stream parser.
package bertlv_pkg;

   typedef enum logic [2:0] {
      ROLE_TCODE = 3'd0,
      ROLE_TLEN  = 3'd1,
      ROLE_TAG   = 3'd2,
      ROLE_LEN   = 3'd3,
      ROLE_VALUE = 3'd4,
      ROLE_TRAIL = 3'd5
   } role_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_TAG_LONG = 2'd1,
      ERR_LEN_WIDE = 2'd2,
      ERR_TRUNC    = 2'd3
   } err_type;

   localparam logic [7:0] TEMPLATE_LO  = 8'hE0;
   localparam logic [7:0] TEMPLATE_HI  = 8'hE9;
   localparam logic [4:0] TAG_MORE_LOW = 5'h1F;

   typedef struct packed {
      role_type    role;
      err_type     err;
      logic        done;
      logic [7:0]  data;
      logic [31:0] tag;
      logic [31:0] len;
      logic [7:0]  tmpl;
   } result_type;

endpackage

FILE: rtl/core/ber_tlv_stream_parser_core.sv
// BER-TLV stream parser: classifies each frame byte and decodes tags and lengths.
//
// The parser takes one frame byte per word and returns one result word per byte,
// naming the role of the byte (template code, template length, tag, length,
// value or ignored trailing byte) together with the tag collected so far, the
// decoded value length, the frame's template code and an error code. The parse
// state and the result register update together on the accepting edge, so a
// new word is taken every cycle while the result register is empty or being
// read, and the result is valid in the cycle after the byte is accepted.
// A frame starting with E0 to E9 is parsed as a template whose length
// bounds the items; a tag longer than MAX_TAG_BYTES, a length field wider than
// MAX_LEN_BYTES, or an unfinished item at frame end is flagged on that byte.
module ber_tlv_stream_parser_core
   import bertlv_pkg::*;
#(
   parameter int MAX_TAG_BYTES = 4,
   parameter int MAX_LEN_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // frame_first
   input  logic        req_tlast,   // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // byte_out, tag_code, value_length, template_code
   output logic [4:0]  rsp_tuser,   // byte_role, error_code
   output logic        rsp_tlast    // item_done
);

   localparam int TagCntW = $clog2(MAX_TAG_BYTES + 1);
   localparam int LenCntW = $clog2(MAX_LEN_BYTES + 1);
   localparam logic [TagCntW-1:0] MaxTagCnt = TagCntW'(MAX_TAG_BYTES);
   localparam logic [6:0]         MaxLenN   = 7'(MAX_LEN_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE, PH_TLEN, PH_TAG, PH_LEN, PH_VALUE, PH_TRAIL
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               intpl_ff, intpl_in;
   logic [7:0]         tid_ff, tid_in;
   logic [31:0]        span_ff, span_in;
   logic [31:0]        cons_ff, cons_in;
   logic [31:0]        tacc_ff, tacc_in;
   logic [TagCntW-1:0] tcnt_ff, tcnt_in;
   logic [31:0]        lacc_ff, lacc_in;
   logic [LenCntW-1:0] lleft_ff, lleft_in;
   logic [31:0]        vleft_ff, vleft_in;

   logic               rsp_valid_ff;
   result_type         rsp_ff, rsp_in;
   logic               accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      logic [7:0] b;
      logic [6:0] n;
      logic       handled;
      logic       done;
      role_type   role;
      err_type    err;

      b        = req_tdata;
      n        = req_tdata[6:0];
      handled  = 1'b0;
      done     = 1'b0;
      role     = ROLE_TRAIL;
      err      = ERR_NONE;
      phase_in = phase_ff;
      intpl_in = intpl_ff;
      tid_in   = tid_ff;
      span_in  = span_ff;
      cons_in  = cons_ff;
      tacc_in  = tacc_ff;
      tcnt_in  = tcnt_ff;
      lacc_in  = lacc_ff;
      lleft_in = lleft_ff;
      vleft_in = vleft_ff;

      if (req_tuser || phase_ff == PH_IDLE) begin
         intpl_in = 1'b0;
         tid_in   = '0;
         span_in  = '0;
         cons_in  = '0;
         tacc_in  = '0;
         tcnt_in  = '0;
         lacc_in  = '0;
         lleft_in = '0;
         vleft_in = '0;
         if (b inside {[TEMPLATE_LO:TEMPLATE_HI]}) begin
            tid_in   = b;
            intpl_in = 1'b1;
            phase_in = PH_TLEN;
            role     = ROLE_TCODE;
            handled  = 1'b1;
         end else begin
            phase_in = PH_TAG;
         end
      end

      if (!handled) begin
         case (phase_in)
            PH_TLEN: begin
               role = ROLE_TLEN;
               if (lleft_in == '0) begin
                  if (b[7]) begin
                     if (n > MaxLenN) begin
                        err      = ERR_LEN_WIDE;
                        phase_in = PH_TRAIL;
                     end else begin
                        span_in  = '0;
                        lleft_in = LenCntW'(n);
                        if (n == 7'd0) begin
                           cons_in  = '0;
                           phase_in = PH_TRAIL;
                        end
                     end
                  end else begin
                     span_in  = {24'd0, b};
                     cons_in  = '0;
                     phase_in = (b == 8'd0) ? PH_TRAIL : PH_TAG;
                     tcnt_in  = '0;
                  end
               end else begin
                  span_in  = {span_in[23:0], b};
                  lleft_in = lleft_in - 1'b1;
                  if (lleft_in == '0) begin
                     cons_in  = '0;
                     tcnt_in  = '0;
                     phase_in = (span_in == '0) ? PH_TRAIL : PH_TAG;
                  end
               end
            end
            PH_TAG, PH_LEN, PH_VALUE: begin
               if (intpl_in && cons_in != 32'hFFFF_FFFF) begin
                  cons_in = cons_in + 32'd1;
               end
               if (phase_in == PH_TAG) begin
                  role = ROLE_TAG;
                  if (tcnt_in == '0) begin
                     tacc_in = {24'd0, b};
                     lacc_in = '0;
                     tcnt_in = TagCntW'(1);
                     if (b[4:0] != TAG_MORE_LOW) begin
                        phase_in = PH_LEN;
                        lleft_in = '0;
                     end
                  end else if (tcnt_in >= MaxTagCnt) begin
                     err      = ERR_TAG_LONG;
                     phase_in = PH_TRAIL;
                  end else begin
                     tacc_in = {tacc_in[23:0], b};
                     tcnt_in = tcnt_in + 1'b1;
                     if (!b[7]) begin
                        phase_in = PH_LEN;
                        lleft_in = '0;
                     end
                  end
               end else if (phase_in == PH_LEN) begin
                  role = ROLE_LEN;
                  if (lleft_in == '0) begin
                     if (b[7]) begin
                        lacc_in = '0;
                        if (n > MaxLenN) begin
                           err      = ERR_LEN_WIDE;
                           phase_in = PH_TRAIL;
                        end else if (n == 7'd0) begin
                           vleft_in = '0;
                           done     = 1'b1;
                        end else begin
                           lleft_in = LenCntW'(n);
                        end
                     end else begin
                        lacc_in  = {24'd0, b};
                        vleft_in = lacc_in;
                        if (lacc_in == '0) done = 1'b1;
                        else phase_in = PH_VALUE;
                     end
                  end else begin
                     lacc_in  = {lacc_in[23:0], b};
                     lleft_in = lleft_in - 1'b1;
                     if (lleft_in == '0) begin
                        vleft_in = lacc_in;
                        if (lacc_in == '0) done = 1'b1;
                        else phase_in = PH_VALUE;
                     end
                  end
               end else begin
                  role = ROLE_VALUE;
                  if (vleft_in != '0) vleft_in = vleft_in - 32'd1;
                  if (vleft_in == '0) done = 1'b1;
               end
               if (done) begin
                  if (intpl_in && cons_in >= span_in) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_TAG;
                     tcnt_in  = '0;
                  end
               end
            end
            default: begin
               role = ROLE_TRAIL;
            end
         endcase
      end

      if (req_tlast) begin
         if (err == ERR_NONE &&
             (phase_in == PH_TLEN || phase_in == PH_LEN || phase_in == PH_VALUE ||
              (phase_in == PH_TAG &&
               (tcnt_in != '0 || (intpl_in && cons_in < span_in))))) begin
            err = ERR_TRUNC;
         end
         phase_in = PH_IDLE;
      end

      rsp_in.role = role;
      rsp_in.err  = err;
      rsp_in.done = done;
      rsp_in.data = b;
      rsp_in.tag  = (role == ROLE_TCODE || role == ROLE_TLEN) ? 32'd0 : tacc_in;
      rsp_in.len  = (role == ROLE_TCODE || role == ROLE_TLEN) ? span_in : lacc_in;
      rsp_in.tmpl = tid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         intpl_ff     <= 1'b0;
         tid_ff       <= '0;
         span_ff      <= '0;
         cons_ff      <= '0;
         tacc_ff      <= '0;
         tcnt_ff      <= '0;
         lacc_ff      <= '0;
         lleft_ff     <= '0;
         vleft_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            intpl_ff <= intpl_in;
            tid_ff   <= tid_in;
            span_ff  <= span_in;
            cons_ff  <= cons_in;
            tacc_ff  <= tacc_in;
            tcnt_ff  <= tcnt_in;
            lacc_ff  <= lacc_in;
            lleft_ff <= lleft_in;
            vleft_ff <= vleft_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.tmpl, rsp_ff.len, rsp_ff.tag, rsp_ff.data};
   assign rsp_tuser  = {rsp_ff.err, rsp_ff.role};
   assign rsp_tlast  = rsp_ff.done;

   // An item can only complete on a length or value byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done |-> rsp_ff.role == ROLE_LEN || rsp_ff.role == ROLE_VALUE)
      else $error("item completion on a byte that is not length or value");

   // A tag that is too long is reported on a tag byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.err == ERR_TAG_LONG |-> rsp_ff.role == ROLE_TAG)
      else $error("tag error reported on a byte that is not a tag");

   // A length field that is too wide is reported on a length byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.err == ERR_LEN_WIDE |->
         rsp_ff.role == ROLE_TLEN || rsp_ff.role == ROLE_LEN)
      else $error("length error reported on a byte that is not a length");

   // The parser only waits for value bytes while some are still owed.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> vleft_ff != '0)
      else $error("value phase with no value bytes left");

   // A template code word echoes its own byte as the template code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.role == ROLE_TCODE |-> rsp_ff.tmpl == rsp_ff.data)
      else $error("template code does not match its byte");

endmodule

FILE: verif/tlv_parse_checker.sv
// Checker for the BER-TLV stream parser: predicts every result word and compares it.
module tlv_parse_checker
   import bertlv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic [4:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          outstanding,
   output int          words_checked
);

   localparam int TAG_LIMIT = 4;
   localparam int LEN_LIMIT = 4;

   typedef enum logic [2:0] {
      P_IDLE  = 3'd0,
      P_TLEN  = 3'd1,
      P_TAG   = 3'd2,
      P_LEN   = 3'd3,
      P_VALUE = 3'd4,
      P_TRAIL = 3'd5
   } parse_phase_type;

   parse_phase_type phase;
   logic        in_tmpl;
   logic [7:0]  tmpl_id;
   logic [31:0] tmpl_span;
   logic [31:0] consumed;
   logic [31:0] tag_acc;
   logic [2:0]  tag_cnt;
   logic [31:0] len_acc;
   logic [2:0]  len_left;
   logic [31:0] value_left;

   result_type expected_results[$];

   function automatic void clear_state();
      phase      = P_IDLE;
      in_tmpl    = 1'b0;
      tmpl_id    = 8'd0;
      tmpl_span  = 32'd0;
      consumed   = 32'd0;
      tag_acc    = 32'd0;
      tag_cnt    = 3'd0;
      len_acc    = 32'd0;
      len_left   = 3'd0;
      value_left = 32'd0;
   endfunction

   function automatic void start_item();
      phase   = P_TAG;
      tag_cnt = 3'd0;
   endfunction

   function automatic void enter_items();
      consumed = 32'd0;
      if (tmpl_span == 32'd0) begin
         phase = P_TRAIL;
      end else begin
         start_item();
      end
   endfunction

   function automatic logic finish_length();
      value_left = len_acc;
      if (value_left == 32'd0) begin
         return 1'b1;
      end
      phase = P_VALUE;
      return 1'b0;
   endfunction

   function automatic result_type parse_byte(input logic [7:0] b, input logic first,
                                             input logic last);
      result_type r;
      role_type   role;
      err_type    err;
      logic       done;
      logic       handled;
      logic [6:0] n;
      role    = ROLE_TRAIL;
      err     = ERR_NONE;
      done    = 1'b0;
      handled = 1'b0;
      if (first || phase == P_IDLE) begin
         clear_state();
         if (b >= TEMPLATE_LO && b <= TEMPLATE_HI) begin
            tmpl_id = b;
            in_tmpl = 1'b1;
            phase   = P_TLEN;
            role    = ROLE_TCODE;
            handled = 1'b1;
         end else begin
            start_item();
         end
      end
      if (!handled) begin
         case (phase)
            P_TLEN: begin
               role = ROLE_TLEN;
               if (len_left == 3'd0) begin
                  if (b[7]) begin
                     n = b[6:0];
                     if (n > LEN_LIMIT) begin
                        err   = ERR_LEN_WIDE;
                        phase = P_TRAIL;
                     end else if (n == 7'd0) begin
                        tmpl_span = 32'd0;
                        enter_items();
                     end else begin
                        tmpl_span = 32'd0;
                        len_left  = n[2:0];
                     end
                  end else begin
                     tmpl_span = {24'd0, b};
                     enter_items();
                  end
               end else begin
                  tmpl_span = {tmpl_span[23:0], b};
                  len_left  = len_left - 3'd1;
                  if (len_left == 3'd0) begin
                     enter_items();
                  end
               end
            end
            P_TAG, P_LEN, P_VALUE: begin
               if (in_tmpl && consumed != 32'hFFFF_FFFF) begin
                  consumed = consumed + 32'd1;
               end
               if (phase == P_TAG) begin
                  role = ROLE_TAG;
                  if (tag_cnt == 3'd0) begin
                     tag_acc = {24'd0, b};
                     len_acc = 32'd0;
                     tag_cnt = 3'd1;
                     if (b[4:0] != TAG_MORE_LOW) begin
                        phase    = P_LEN;
                        len_left = 3'd0;
                     end
                  end else if (tag_cnt >= TAG_LIMIT) begin
                     err   = ERR_TAG_LONG;
                     phase = P_TRAIL;
                  end else begin
                     tag_acc = {tag_acc[23:0], b};
                     tag_cnt = tag_cnt + 3'd1;
                     if (!b[7]) begin
                        phase    = P_LEN;
                        len_left = 3'd0;
                     end
                  end
               end else if (phase == P_LEN) begin
                  role = ROLE_LEN;
                  if (len_left == 3'd0) begin
                     if (b[7]) begin
                        n       = b[6:0];
                        len_acc = 32'd0;
                        if (n > LEN_LIMIT) begin
                           err   = ERR_LEN_WIDE;
                           phase = P_TRAIL;
                        end else if (n == 7'd0) begin
                           done = finish_length();
                        end else begin
                           len_left = n[2:0];
                        end
                     end else begin
                        len_acc = {24'd0, b};
                        done    = finish_length();
                     end
                  end else begin
                     len_acc  = {len_acc[23:0], b};
                     len_left = len_left - 3'd1;
                     if (len_left == 3'd0) begin
                        done = finish_length();
                     end
                  end
               end else begin
                  role = ROLE_VALUE;
                  if (value_left != 32'd0) begin
                     value_left = value_left - 32'd1;
                  end
                  if (value_left == 32'd0) begin
                     done = 1'b1;
                  end
               end
               if (done) begin
                  if (in_tmpl && consumed >= tmpl_span) begin
                     phase = P_TRAIL;
                  end else begin
                     start_item();
                  end
               end
            end
            default: begin
               role = ROLE_TRAIL;
            end
         endcase
      end
      if (last) begin
         if (err == ERR_NONE &&
             (phase == P_TLEN || phase == P_LEN || phase == P_VALUE ||
              (phase == P_TAG &&
               (tag_cnt != 3'd0 || (in_tmpl && consumed < tmpl_span))))) begin
            err = ERR_TRUNC;
         end
         phase = P_IDLE;
      end
      r.role = role;
      r.err  = err;
      r.done = done;
      r.data = b;
      r.tag  = (role == ROLE_TCODE || role == ROLE_TLEN) ? 32'd0 : tag_acc;
      r.len  = (role == ROLE_TCODE || role == ROLE_TLEN) ? tmpl_span : len_acc;
      r.tmpl = tmpl_id;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_state();
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result word with none expected: data 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("byte_role", 32'(want.role), 32'(rsp_tuser[2:0]));
               check_field("error_code", 32'(want.err), 32'(rsp_tuser[4:3]));
               check_field("item_done", 32'(want.done), 32'(rsp_tlast));
               check_field("byte_out", 32'(want.data), 32'(rsp_tdata[7:0]));
               check_field("tag_code", want.tag, rsp_tdata[39:8]);
               check_field("value_length", want.len, rsp_tdata[71:40]);
               check_field("template_code", 32'(want.tmpl), 32'(rsp_tdata[79:72]));
               words_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    parse_byte(req_tdata, req_tuser, req_tlast));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

FILE: verif/tb.sv
// Testbench top for the BER-TLV stream parser: frame stimulus, flow control and verdict.
module tb;
   import bertlv_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          outstanding;
   int          words_checked;

   frame_byte_type stim_q[$];
   logic [7:0]  build_q[$];
   int          frame_count;
   int          directed_count;

   always #5 clock = ~clock;

   ber_tlv_stream_parser_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tlv_parse_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   task automatic put(input logic [7:0] data, input logic first, input logic last);
      frame_byte_type w;
      w.data  = data;
      w.first = first;
      w.last  = last;
      stim_q.insert(stim_q.size(), w);
   endtask

   task automatic add_byte(input logic [7:0] b);
      build_q.insert(build_q.size(), b);
   endtask

   task automatic add_tag();
      int         k;
      int         count;
      logic [7:0] b;
      k = $urandom_range(0, 99);
      count = (k < 70) ? 1 : (k < 95) ? $urandom_range(2, 4) : $urandom_range(5, 6);
      b = 8'($urandom);
      if (count == 1) begin
         if (b[4:0] == TAG_MORE_LOW) b[0] = 1'b0;
      end else begin
         b[4:0] = TAG_MORE_LOW;
      end
      add_byte(b);
      for (int i = 1; i < count; i++) begin
         b    = 8'($urandom);
         b[7] = (i < count - 1);
         add_byte(b);
      end
   endtask

   task automatic add_length(input logic [31:0] value);
      int         k;
      int         width;
      logic [7:0] b;
      k = $urandom_range(0, 99);
      if (k < 4) begin
         b = 8'($urandom_range(5, 127));
         b[7] = 1'b1;
         add_byte(b);
         return;
      end
      if (value == 32'd0 && k < 15) begin
         add_byte(8'h80);
         return;
      end
      if (value < 32'd128 && k < 65) begin
         add_byte(value[7:0]);
         return;
      end
      width = (value > 32'hFF_FFFF) ? 4 : (value > 32'hFFFF) ? 3 : (value > 32'hFF) ? 2 : 1;
      width = $urandom_range(width, 4);
      b = 8'(width);
      b[7] = 1'b1;
      add_byte(b);
      for (int i = width - 1; i >= 0; i--) add_byte(value[8*i +: 8]);
   endtask

   task automatic add_item();
      int          k;
      logic [31:0] len;
      int          count;
      add_tag();
      k = $urandom_range(0, 99);
      if (k < 10) len = 0;
      else if (k < 87) len = $urandom_range(1, 6);
      else if (k < 97) len = $urandom_range(7, 40);
      else len = $urandom;
      add_length(len);
      count = (len > 40) ? $urandom_range(0, 4) : len;
      repeat (count) add_byte(8'($urandom));
   endtask

   task automatic add_frame();
      logic [7:0]  items_q[$];
      logic [7:0]  code;
      logic [31:0] span;
      int          k;
      int          cut;
      bit          drop_first;
      bit          drop_last;
      build_q.delete();
      repeat ($urandom_range(1, 4)) add_item();
      if ($urandom_range(0, 99) < 45) begin
         items_q = build_q;
         build_q.delete();
         code = 8'(TEMPLATE_LO + $urandom_range(0, 9));
         add_byte(code);
         span = items_q.size();
         k = $urandom_range(0, 99);
         if (k < 8) span = $urandom_range(0, span);
         else if (k < 16) span = span + $urandom_range(1, 3);
         else if (k < 19) span = $urandom;
         add_length(span);
         foreach (items_q[i]) add_byte(items_q[i]);
      end
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      cut = build_q.size();
      if (cut > 1 && $urandom_range(0, 99) < 12) cut = $urandom_range(1, cut - 1);
      drop_first = ($urandom_range(0, 99) < 8);
      drop_last  = ($urandom_range(0, 99) < 5);
      for (int i = 0; i < cut; i++) begin
         put(build_q[i], (i == 0) && !drop_first, (i == cut - 1) && !drop_last);
      end
      frame_count++;
   endtask

   // Receiver: a stall pattern that steps through four modes in turn, plus one long hold-off.
   initial begin
      int c;
      rsp_tready = 1'b0;
      c = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (c == 700) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         case ((c / 200) % 4)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 99) < 55);
            2:       rsp_tready <= ((c % 5) != 0);
            default: rsp_tready <= ($urandom_range(0, 99) < 85);
         endcase
         c++;
         @(negedge clock);
      end
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int burst_left;
      int gap;
      int mid_pause;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      burst_left  = 0;
      frame_count = 0;

      // Byte without a frame start, long form with no bytes, tag cut off by frame end.
      put(8'h00, 1'b0, 1'b0);
      put(8'h80, 1'b0, 1'b0);
      put(8'hFF, 1'b0, 1'b1);
      // Template of zero length followed by a trailing byte.
      put(8'hE9, 1'b1, 1'b0);
      put(8'h00, 1'b0, 1'b0);
      put(8'hAA, 1'b0, 1'b1);
      // Template overrun: span of two, item of three bytes, then trailing.
      put(8'hE0, 1'b1, 1'b0);
      put(8'h81, 1'b0, 1'b0);
      put(8'h02, 1'b0, 1'b0);
      put(8'h01, 1'b0, 1'b0);
      put(8'h01, 1'b0, 1'b0);
      put(8'hFF, 1'b0, 1'b0);
      put(8'h55, 1'b0, 1'b1);
      // Tag longer than the limit.
      put(8'h1F, 1'b1, 1'b0);
      put(8'h81, 1'b0, 1'b0);
      put(8'h82, 1'b0, 1'b0);
      put(8'h83, 1'b0, 1'b0);
      put(8'h84, 1'b0, 1'b1);
      // Length field wider than the limit.
      put(8'h5F, 1'b1, 1'b0);
      put(8'h01, 1'b0, 1'b0);
      put(8'h85, 1'b0, 1'b0);
      put(8'h00, 1'b0, 1'b1);
      // Restart in the middle of a length, then a template cut short.
      put(8'h02, 1'b1, 1'b0);
      put(8'h84, 1'b0, 1'b0);
      put(8'hFF, 1'b0, 1'b0);
      put(8'hE5, 1'b1, 1'b0);
      put(8'h7F, 1'b0, 1'b1);
      frame_count    = 7;
      directed_count = stim_q.size();

      while (stim_q.size() < 1050) begin
         if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 5)) begin
               put(8'($urandom), ($urandom_range(0, 4) == 0), ($urandom_range(0, 4) == 0));
            end
         end else begin
            add_frame();
         end
      end
      mid_pause = directed_count + (stim_q.size() - directed_count) / 2;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_q[i]) begin
         if (i == directed_count || i == mid_pause) begin
            req_tvalid <= 1'b0;
            do @(negedge clock); while (outstanding != 0);
         end
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stim_q[i].data;
         req_tuser  <= stim_q[i].first;
         req_tlast  <= stim_q[i].last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst_left--;
         @(negedge clock);
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Run covered %0d bytes in %0d frames (%0d directed); %0d words compared.",
               stim_q.size(), frame_count, directed_count, words_checked);
      $display("Frames mixed templates, long-form lengths, oversize fields, cuts and restarts.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
